/* hw/rtl/nns_pkg.sv */
// Shared constants and types for the nearest-neighbor image scaler.
// No dependencies; imported by the scaler, its checker and the testbench.

package nns_pkg;

	// fixed field widths
	localparam int SIZE_W      = 8;    // src_width / src_height registers
	localparam int DSIZE_W     = 11;   // dst_width / dst_height registers
	localparam int SCRD_W      = 7;    // src_x / src_y
	localparam int DCRD_W      = 10;   // dst_x / dst_y
	localparam int COLOR_W     = 8;
	localparam int PIX_CH      = 3;    // R, G, B in the frame store
	localparam int PIX_W       = PIX_CH * COLOR_W;
	localparam int OUT_CHANNELS = 4;   // R, G, B, A on the output
	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;

	// stream and APB port widths
	localparam int S_TDATA_W = 64;     // 58 payload bits padded to whole bytes
	localparam int M_TDATA_W = OUT_CHANNELS * COLOR_W;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// s_tdata field offsets
	localparam int SX_LSB    = 0;
	localparam int SY_LSB    = SX_LSB + SCRD_W;
	localparam int RED_LSB   = SY_LSB + SCRD_W;
	localparam int GREEN_LSB = RED_LSB + COLOR_W;
	localparam int BLUE_LSB  = GREEN_LSB + COLOR_W;
	localparam int DX_LSB    = BLUE_LSB + COLOR_W;
	localparam int DY_LSB    = DX_LSB + DCRD_W;

	// parameter defaults
	localparam int DEF_MAX_SRC_WIDTH  = 128;
	localparam int DEF_MAX_SRC_HEIGHT = 128;
	localparam int DEF_MAX_DST_SIZE   = 1024;

	// register reset values
	localparam logic [SIZE_W-1:0]  RST_SRC_WIDTH  = 8'd128;
	localparam logic [SIZE_W-1:0]  RST_SRC_HEIGHT = 8'd128;
	localparam logic [DSIZE_W-1:0] RST_DST_WIDTH  = 11'd0;
	localparam logic [DSIZE_W-1:0] RST_DST_HEIGHT = 11'd0;

	// register index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} reg_idx_t;

endpackage

/* hw/rtl/nns_ram.sv */
// Generic single-port synchronous RAM, registered read, read-first.
// No dependencies.

module nns_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule

/* hw/rtl/nns_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Requires n < d * 2**QW. Uses nothing from the package.

module nns_div #(
	parameter int QW  = 7,
	parameter int NW  = 18,
	parameter int DVW = 11
) (
	input  logic           clk,
	input  logic [NW-1:0]  n,
	input  logic [DVW-1:0] d,
	output logic [QW-1:0]  q
);

	localparam int EW = QW + DVW;

	logic [EW-1:0]  n_ext;
	logic [DVW-1:0] rem_q  [0:QW];
	logic [QW-1:0]  lq_q   [0:QW];   // remaining dividend bits, quotient shifts in
	logic [DVW-1:0] d_q    [0:QW];
	logic [DVW:0]   trial  [0:QW-1];
	logic [DVW:0]   diff   [0:QW-1];
	logic           ge     [0:QW-1];
	logic [DVW-1:0] rem_nx [0:QW-1];
	logic [QW-1:0]  lq_nx  [0:QW-1];

	// upper bits beyond DVW+QW are zero given the precondition
	assign n_ext = EW'(n);

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			trial[k]  = {rem_q[k], lq_q[k][QW-1]};
			diff[k]   = trial[k] - {1'b0, d_q[k]};
			ge[k]     = trial[k] >= {1'b0, d_q[k]};
			rem_nx[k] = ge[k] ? diff[k][DVW-1:0] : trial[k][DVW-1:0];
			lq_nx[k]  = (lq_q[k] << 1) | QW'(ge[k]);
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= n_ext[EW-1:QW];
		lq_q[0]  <= n_ext[QW-1:0];
		d_q[0]   <= d;
		for (int k = 0; k < QW; k++) begin
			rem_q[k+1] <= rem_nx[k];
			lq_q[k+1]  <= lq_nx[k];
			d_q[k+1]   <= d_q[k];
		end
	end

	assign q = lq_q[QW];

endmodule

/* hw/rtl/nearest_neighbor_image_scaler_unit.sv */
// Nearest-neighbor image scaler: frame store, coordinate dividers, output queue.
// Depends on nns_pkg, nns_div and nns_ram.
//
// Usage
//   APB port: four size registers at byte addresses 0, 4, 8, 12 (src_width,
//   src_height, dst_width, dst_height); pready is tied high, reads return the
//   stored register. Write them only while no transfer is in flight.
//   Input stream (s_*): s_tuser low writes an RGB pixel into the frame store at
//   (src_x, src_y); s_tuser high asks for destination pixel (dst_x, dst_y).
//   Writes produce nothing on the output. Each read produces one RGBA transfer
//   on m_*, with m_tuser flagging a coordinate outside the output size.
// Timing
//   One transfer per cycle in both directions while m_tready is high and the
//   output queue has a free slot. A read passes the QW+1 stages of the two
//   coordinate dividers (QW = clog2 of the larger maximum source size), the
//   frame-store read register and the queue push before it leaves on m_*.
//   Items pass through the store in order, so a read always sees every
//   earlier write.
// Reset and stalls
//   arst_n clears the registers to 128/128/0/0 and empties the pipeline; the
//   frame store is not cleared and must be written before it is read.
//   A stalled m_tready fills an output queue sized to the pipeline depth;
//   s_tready falls only when every queue slot is claimed by reads in flight.

module nearest_neighbor_image_scaler_unit #(
	parameter int MAX_SRC_WIDTH  = nns_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = nns_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int MAX_DST_SIZE   = nns_pkg::DEF_MAX_DST_SIZE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nns_pkg::APB_AW-1:0]    paddr,
	input  logic [nns_pkg::APB_DW-1:0]    pwdata,
	output logic [nns_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata fields, low bit up: src_x[7], src_y[7], in_red[8], in_green[8],
	// in_blue[8], dst_x[10], dst_y[10], zero pad[6]
	input  logic [nns_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser fields: operation[1] (0 write, 1 read)
	input  logic                          s_tuser,
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata fields, low bit up: out_red[8], out_green[8], out_blue[8],
	// out_alpha[8]
	output logic [nns_pkg::M_TDATA_W-1:0] m_tdata,
	// m_tuser fields: out_of_range[1]
	output logic                          m_tuser
);

	import nns_pkg::*;

	// divider depth covers the larger quotient range
	localparam int QXW   = $clog2(MAX_SRC_WIDTH);
	localparam int QYW   = $clog2(MAX_SRC_HEIGHT);
	localparam int ND    = (QXW > QYW) ? QXW : QYW;
	localparam int NW    = SIZE_W + DCRD_W;           // scaled coordinate width
	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	// queue holds every read that can be in flight at once
	localparam int QD    = 2 ** $clog2(ND + 4);
	localparam int PW    = $clog2(QD);
	localparam int CW    = $clog2(QD + 1);
	localparam int QEW   = M_TDATA_W + 1;

	typedef struct packed {
		logic             rd;      // read request
		logic             oor;     // outside the output size
		logic             wr_ok;   // write lands inside the store
		logic [AW-1:0]    waddr;
		logic [PIX_W-1:0] wdata;   // {R, G, B}
	} side_t;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [SIZE_W-1:0]  src_width_q, src_height_q;
	logic [DSIZE_W-1:0] dst_width_q, dst_height_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			dst_width_q  <= RST_DST_WIDTH;
			dst_height_q <= RST_DST_HEIGHT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SRC_WIDTH:  src_width_q  <= pwdata[SIZE_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[SIZE_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= pwdata[DSIZE_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= pwdata[DSIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_SRC_WIDTH:  prdata = APB_DW'(src_width_q);
			REG_SRC_HEIGHT: prdata = APB_DW'(src_height_q);
			REG_DST_WIDTH:  prdata = APB_DW'(dst_width_q);
			REG_DST_HEIGHT: prdata = APB_DW'(dst_height_q);
		endcase
	end

	// ---------------------------------------------------------------
	// effective sizes (user keeps config static while items in flight; unchecked)
	// ---------------------------------------------------------------
	logic [SIZE_W-1:0]  sw_eff, sh_eff;
	logic [DSIZE_W-1:0] ow_clip, oh_clip, ow_eff, oh_eff;

	always_comb begin
		// zero source size counts as one, oversize clips to the store
		if (src_width_q == '0) sw_eff = SIZE_W'(1);
		else if (32'(src_width_q) > MAX_SRC_WIDTH) sw_eff = SIZE_W'(MAX_SRC_WIDTH);
		else sw_eff = src_width_q;

		if (src_height_q == '0) sh_eff = SIZE_W'(1);
		else if (32'(src_height_q) > MAX_SRC_HEIGHT) sh_eff = SIZE_W'(MAX_SRC_HEIGHT);
		else sh_eff = src_height_q;

		ow_clip = (32'(dst_width_q) > MAX_DST_SIZE) ? DSIZE_W'(MAX_DST_SIZE) : dst_width_q;
		oh_clip = (32'(dst_height_q) > MAX_DST_SIZE) ? DSIZE_W'(MAX_DST_SIZE) : dst_height_q;

		// either destination size zero: no scaling at all
		if (ow_clip == '0 || oh_clip == '0) begin
			ow_eff = DSIZE_W'(sw_eff);
			oh_eff = DSIZE_W'(sh_eff);
		end else begin
			ow_eff = ow_clip;
			oh_eff = oh_clip;
		end
	end

	// ---------------------------------------------------------------
	// input decode
	// ---------------------------------------------------------------
	logic              s_xfer, rd_xfer;
	logic [SCRD_W-1:0] in_sx, in_sy;
	logic [DCRD_W-1:0] in_dx, in_dy;
	logic [NW-1:0]     nx, ny;
	side_t             side_in;

	assign s_xfer  = s_tvalid & s_tready;
	assign rd_xfer = s_xfer & s_tuser;
	assign in_sx   = s_tdata[SX_LSB +: SCRD_W];
	assign in_sy   = s_tdata[SY_LSB +: SCRD_W];
	assign in_dx   = s_tdata[DX_LSB +: DCRD_W];
	assign in_dy   = s_tdata[DY_LSB +: DCRD_W];

	// scaled coordinates feeding the dividers
	assign nx = NW'(sw_eff) * NW'(in_dx);
	assign ny = NW'(sh_eff) * NW'(in_dy);

	always_comb begin
		side_in.rd    = s_tuser;
		side_in.oor   = ({1'b0, in_dx} >= ow_eff) || ({1'b0, in_dy} >= oh_eff);
		side_in.wr_ok = (32'(in_sx) < MAX_SRC_WIDTH) && (32'(in_sy) < MAX_SRC_HEIGHT);
		side_in.waddr = AW'(32'(in_sy) * MAX_SRC_WIDTH + 32'(in_sx));
		side_in.wdata = {s_tdata[RED_LSB +: COLOR_W], s_tdata[GREEN_LSB +: COLOR_W],
			s_tdata[BLUE_LSB +: COLOR_W]};
	end

	// ---------------------------------------------------------------
	// coordinate dividers: sx = sw*dx/ow, sy = sh*dy/oh
	// ---------------------------------------------------------------
	logic [ND-1:0] qx, qy;

	nns_div #(.QW(ND), .NW(NW), .DVW(DSIZE_W)) u_div_x (
		.clk (clk),
		.n   (nx),
		.d   (ow_eff),
		.q   (qx)
	);

	nns_div #(.QW(ND), .NW(NW), .DVW(DSIZE_W)) u_div_y (
		.clk (clk),
		.n   (ny),
		.d   (oh_eff),
		.q   (qy)
	);

	// sideband delay line matched to the divider latency
	logic  sb_vld_q [0:ND];
	side_t sb_q     [0:ND];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ND; k++) begin
				sb_vld_q[k] <= 1'b0;
			end
		end else begin
			sb_vld_q[0] <= s_xfer;
			for (int k = 0; k < ND; k++) begin
				sb_vld_q[k+1] <= sb_vld_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		sb_q[0] <= side_in;
		for (int k = 0; k < ND; k++) begin
			sb_q[k+1] <= sb_q[k];
		end
	end

	// ---------------------------------------------------------------
	// frame store access, reads and writes in arrival order
	// ---------------------------------------------------------------
	logic [ND-1:0]    sx_c, sy_c;
	logic [AW-1:0]    raddr, ram_addr;
	logic             ram_en, ram_we;
	logic [PIX_W-1:0] ram_rdata;

	always_comb begin
		sx_c = (32'(qx) >= MAX_SRC_WIDTH)  ? ND'(MAX_SRC_WIDTH - 1)  : qx;
		sy_c = (32'(qy) >= MAX_SRC_HEIGHT) ? ND'(MAX_SRC_HEIGHT - 1) : qy;
		raddr = AW'(32'(sy_c) * MAX_SRC_WIDTH + 32'(sx_c));
	end

	assign ram_en   = sb_vld_q[ND];
	assign ram_we   = sb_vld_q[ND] & ~sb_q[ND].rd & sb_q[ND].wr_ok;
	assign ram_addr = sb_q[ND].rd ? raddr : sb_q[ND].waddr;

	nns_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (sb_q[ND].wdata),
		.rdata (ram_rdata)
	);

	logic rd_vld_q;
	logic rd_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= sb_vld_q[ND] & sb_q[ND].rd;
		end
	end

	always_ff @(posedge clk) begin
		rd_oor_q <= sb_q[ND].oor;
	end

	// ---------------------------------------------------------------
	// output queue with credit count on reads in flight
	// ---------------------------------------------------------------
	logic [QEW-1:0] q_mem_q [0:QD-1];
	logic [QEW-1:0] push_data;
	logic [PW:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  credit_q;
	logic           m_xfer;

	// out-of-range result: all bytes zero
	assign push_data = rd_oor_q ? {1'b1, {M_TDATA_W{1'b0}}} :
		{1'b0, ALPHA_OPAQUE, ram_rdata[COLOR_W-1:0],
		ram_rdata[2*COLOR_W-1:COLOR_W], ram_rdata[PIX_W-1:2*COLOR_W]};

	assign m_xfer   = m_tvalid & m_tready;
	assign m_tvalid = wr_ptr_q != rd_ptr_q;
	assign {m_tuser, m_tdata} = q_mem_q[rd_ptr_q[PW-1:0]];
	assign s_tready = credit_q < CW'(QD);

	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			q_mem_q[wr_ptr_q[PW-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			credit_q <= '0;
		end else begin
			if (rd_vld_q) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (m_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			credit_q <= credit_q + CW'(rd_xfer) - CW'(m_xfer);
		end
	end

endmodule

/* hw/rtl/nns_checker.sv */
// Port-level checks for the nearest-neighbor image scaler, bound to the top.
// Depends on nns_pkg.

module nns_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [nns_pkg::APB_AW-1:0]    paddr,
	input logic [nns_pkg::APB_DW-1:0]    pwdata,
	input logic [nns_pkg::APB_DW-1:0]    prdata,
	input logic                          pready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [nns_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	import nns_pkg::*;

	// a pending result is not withdrawn
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped before transfer");

	// out-of-range results carry all-zero bytes
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out-of-range result with nonzero data");

	// in-range results are opaque
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[M_TDATA_W-1 -: COLOR_W] == ALPHA_OPAQUE)
		else $error("in-range result alpha not opaque");

	// a written source width reads back on the next cycle
	a_cfg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[3:2] == REG_SRC_WIDTH)
		##1 (paddr[3:2] == REG_SRC_WIDTH)
		|-> prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
		else $error("src_width readback mismatch");

endmodule

bind nearest_neighbor_image_scaler_unit nns_checker u_nns_checker (.*);

/* sim/tb_nearest_neighbor_image_scaler_unit.sv */
// Self-checking testbench for the nearest-neighbor image scaler: APB size setup,
// pixel writes and destination reads on the streams, results checked in order.
// Depends on nns_pkg and the scaler RTL; needs no files or arguments at run time.
`timescale 1ns / 1ps

module tb_nearest_neighbor_image_scaler_unit;
	import nns_pkg::*;

	localparam int MAX_SW         = DEF_MAX_SRC_WIDTH;
	localparam int MAX_SH         = DEF_MAX_SRC_HEIGHT;
	localparam int MAX_DST        = DEF_MAX_DST_SIZE;
	localparam int DRAIN_CYCLES   = 16;    // idle wait after each phase's drain
	localparam int STALL_LIMIT    = 5000;  // cycles with no transfer anywhere
	localparam int HOLD_CYCLES    = 300;   // long m_tready hold-off, fills the output queue
	localparam int RAND_PER_PHASE = 160;
	localparam int NUM_PHASES     = 9;

	// s_tuser encoding
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} pix_op_e;

	typedef struct packed {
		pix_op_e             op;
		logic [SCRD_W-1:0]   sx;
		logic [SCRD_W-1:0]   sy;
		logic [COLOR_W-1:0]  r;
		logic [COLOR_W-1:0]  g;
		logic [COLOR_W-1:0]  b;
		logic [DCRD_W-1:0]   dx;
		logic [DCRD_W-1:0]   dy;
	} pix_req_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  r;
		logic [COLOR_W-1:0]  g;
		logic [COLOR_W-1:0]  b;
		logic [COLOR_W-1:0]  a;
		logic                oor;
	} rgba_t;

	// one line of the directed stimulus; typed rows carry their answer
	typedef struct packed {
		pix_req_t            req;
		bit                  typed;
		rgba_t               want;
	} dir_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [APB_AW-1:0]    paddr    = '0;
	logic [APB_DW-1:0]    pwdata   = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// src_x, src_y, in_red, in_green, in_blue, dst_x, dst_y, zero pad (low bit up)
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// operation
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// out_red, out_green, out_blue, out_alpha (low bit up)
	logic [M_TDATA_W-1:0] m_tdata;
	// out_of_range
	logic                 m_tuser;

	// shadow copy of the size registers and of the frame store
	logic [SIZE_W-1:0]    cfg_sw = RST_SRC_WIDTH;
	logic [SIZE_W-1:0]    cfg_sh = RST_SRC_HEIGHT;
	logic [DSIZE_W-1:0]   cfg_dw = RST_DST_WIDTH;
	logic [DSIZE_W-1:0]   cfg_dh = RST_DST_HEIGHT;
	logic [PIX_W-1:0]     pix_mem [MAX_SW*MAX_SH];
	bit                   pix_written [MAX_SW*MAX_SH];

	rgba_t                pending_px [$];  // expected output transfers, oldest first
	rgba_t                mon_want;
	dir_row_t             dir_rows [$];
	int                   errors       = 0;
	int                   tx_idle_pct  = 0;
	int                   rx_idle_pct  = 0;
	int                   hold_req     = 0;
	int                   hold_ack     = 0;
	int                   hold_left    = 0;
	int                   quiet_cycles = 0;

	nearest_neighbor_image_scaler_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Effective sizes: source clamped to 1..max, destination clamped to max,
	// and a zero in either destination size falls back to the source sizes.
	function automatic void eff_sizes(output int sw, output int sh, output int ow,
			output int oh);
		sw = (cfg_sw == 0) ? 1 : (cfg_sw > MAX_SW) ? MAX_SW : int'(cfg_sw);
		sh = (cfg_sh == 0) ? 1 : (cfg_sh > MAX_SH) ? MAX_SH : int'(cfg_sh);
		ow = (cfg_dw > MAX_DST) ? MAX_DST : int'(cfg_dw);
		oh = (cfg_dh > MAX_DST) ? MAX_DST : int'(cfg_dh);
		if (ow == 0 || oh == 0) begin
			ow = sw;
			oh = sh;
		end
	endfunction

	// Store index that a destination coordinate maps to, -1 when outside the output.
	function automatic int src_index(input logic [DCRD_W-1:0] dx, input logic [DCRD_W-1:0] dy);
		int sw, sh, ow, oh;
		eff_sizes(sw, sh, ow, oh);
		if (int'(dx) >= ow || int'(dy) >= oh)
			return -1;
		return ((sh * int'(dy)) / oh) * MAX_SW + (sw * int'(dx)) / ow;
	endfunction

	function automatic rgba_t resample_pixel(input pix_req_t q);
		rgba_t px;
		int    idx;
		idx = src_index(q.dx, q.dy);
		px  = '0;
		if (idx < 0) begin
			px.oor = 1'b1;
		end else begin
			{px.r, px.g, px.b} = pix_mem[idx];
			px.a = ALPHA_OPAQUE;
		end
		return px;
	endfunction

	// Update the shadow store or queue the expected pixel for one accepted transfer.
	function automatic void track_transfer(input pix_req_t q, input bit typed, input rgba_t want);
		if (q.op == OP_WRITE) begin
			pix_mem[{q.sy, q.sx}]     = {q.r, q.g, q.b};
			pix_written[{q.sy, q.sx}] = 1'b1;
		end else begin
			pending_px.push_back(typed ? want : resample_pixel(q));
		end
	endfunction

	function automatic pix_req_t rand_req();
		pix_req_t q;
		q.op = pix_op_e'($urandom_range(0, 1));
		q.sx = SCRD_W'($urandom);
		q.sy = SCRD_W'($urandom);
		q.r  = COLOR_W'($urandom);
		q.g  = COLOR_W'($urandom);
		q.b  = COLOR_W'($urandom);
		q.dx = DCRD_W'($urandom);
		q.dy = DCRD_W'($urandom);
		return q;
	endfunction

	function automatic dir_row_t wr_row(input int x, input int y, input logic [PIX_W-1:0] rgb);
		dir_row_t d;
		d = '0;
		d.req.op = OP_WRITE;
		d.req.sx = SCRD_W'(x);
		d.req.sy = SCRD_W'(y);
		{d.req.r, d.req.g, d.req.b} = rgb;
		d.req.dx = '1;
		d.req.dy = '1;
		return d;
	endfunction

	function automatic dir_row_t rd_row(input int x, input int y, input bit oor,
			input logic [PIX_W-1:0] rgb);
		dir_row_t d;
		d = '0;
		d.req.op = OP_READ;
		d.req.sx = '1;
		d.req.sy = '1;
		{d.req.r, d.req.g, d.req.b} = '1;
		d.req.dx = DCRD_W'(x);
		d.req.dy = DCRD_W'(y);
		d.typed = 1'b1;
		d.want.oor = oor;
		if (!oor) begin
			{d.want.r, d.want.g, d.want.b} = rgb;
			d.want.a = ALPHA_OPAQUE;
		end
		return d;
	endfunction

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_xfer(input reg_idx_t idx, input bit wr, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata   = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [APB_DW-1:0] want);
		logic [APB_DW-1:0] rd;
		apb_xfer(idx, 1'b0, '0, rd);
		if (rd !== want) begin
			$error("%s: expected %0d, actual %0d", idx.name(), want, rd);
			errors++;
		end
	endtask

	task automatic set_reg(input reg_idx_t idx, input int val);
		logic [APB_DW-1:0] rd;
		logic [APB_DW-1:0] want;
		apb_xfer(idx, 1'b1, APB_DW'(val), rd);
		case (idx)
			REG_SRC_WIDTH: begin
				cfg_sw = SIZE_W'(val);
				want = APB_DW'(cfg_sw);
			end
			REG_SRC_HEIGHT: begin
				cfg_sh = SIZE_W'(val);
				want = APB_DW'(cfg_sh);
			end
			REG_DST_WIDTH: begin
				cfg_dw = DSIZE_W'(val);
				want = APB_DW'(cfg_dw);
			end
			default: begin
				cfg_dh = DSIZE_W'(val);
				want = APB_DW'(cfg_dh);
			end
		endcase
		check_reg(idx, want);
	endtask

	task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
		set_reg(REG_SRC_WIDTH, sw);
		set_reg(REG_SRC_HEIGHT, sh);
		set_reg(REG_DST_WIDTH, dw);
		set_reg(REG_DST_HEIGHT, dh);
	endtask

	// Offer one item after a random gap; valid stays up into the next item
	// unless a gap or the end of the phase lowers it.
	task automatic send_px(input pix_req_t q, input bit typed, input rgba_t want);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= q.op;
		s_tdata  <= S_TDATA_W'({q.dy, q.dx, q.b, q.g, q.r, q.sy, q.sx});
		do @(posedge clk); while (!s_tready);
		track_transfer(q, typed, want);
	endtask

	// Drop valid and wait until every queued pixel has come out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_px.size() != 0);
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	// Receiver: random stalls, plus a long hold-off on request from the stimulus.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Output checker: every result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_px.size() == 0) begin
				$error("result transfer with nothing expected: tdata %h tuser %b",
					m_tdata, m_tuser);
				errors++;
			end else begin
				mon_want = pending_px.pop_front();
				check_field("out_red",      int'(mon_want.r),
					int'(m_tdata[0*COLOR_W +: COLOR_W]));
				check_field("out_green",    int'(mon_want.g),
					int'(m_tdata[1*COLOR_W +: COLOR_W]));
				check_field("out_blue",     int'(mon_want.b),
					int'(m_tdata[2*COLOR_W +: COLOR_W]));
				check_field("out_alpha",    int'(mon_want.a),
					int'(m_tdata[3*COLOR_W +: COLOR_W]));
				check_field("out_of_range", int'(mon_want.oor), int'(m_tuser));
			end
		end
	end

	// Watchdog: a long run of cycles with no transfer on any port ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_nearest_neighbor_image_scaler_unit failed");
			$finish;
		end
	end

	initial begin
		pix_req_t q;
		pix_req_t fill;
		int       sw, sh, ow, oh;
		int       sel, idx;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// registers come out of reset at 128/128/0/0
		check_reg(REG_SRC_WIDTH,  APB_DW'(RST_SRC_WIDTH));
		check_reg(REG_SRC_HEIGHT, APB_DW'(RST_SRC_HEIGHT));
		check_reg(REG_DST_WIDTH,  APB_DW'(RST_DST_WIDTH));
		check_reg(REG_DST_HEIGHT, APB_DW'(RST_DST_HEIGHT));

		// Directed rows under the reset sizes: zero destination size means the
		// output is the 128x128 source itself, so reads are identity lookups.
		dir_rows.push_back(wr_row(0,   0,   24'hFF0080));
		dir_rows.push_back(wr_row(127, 127, 24'h00FF7F));
		dir_rows.push_back(wr_row(127, 0,   24'h123456));
		dir_rows.push_back(wr_row(0,   127, 24'hABCDEF));
		dir_rows.push_back(wr_row(64,  33,  24'h000000));
		dir_rows.push_back(rd_row(0,   0,   1'b0, 24'hFF0080));
		dir_rows.push_back(rd_row(127, 127, 1'b0, 24'h00FF7F));
		dir_rows.push_back(rd_row(127, 0,   1'b0, 24'h123456));
		dir_rows.push_back(rd_row(0,   127, 1'b0, 24'hABCDEF));
		dir_rows.push_back(rd_row(64,  33,  1'b0, 24'h000000));
		// just past the output edge in x, in y, both, and the far corner
		dir_rows.push_back(rd_row(128,  5,    1'b1, '0));
		dir_rows.push_back(rd_row(5,    128,  1'b1, '0));
		dir_rows.push_back(rd_row(128,  128,  1'b1, '0));
		dir_rows.push_back(rd_row(1023, 1023, 1'b1, '0));
		// overwrite, then read straight behind it
		dir_rows.push_back(wr_row(0, 0, 24'h010203));
		dir_rows.push_back(rd_row(0, 0, 1'b0, 24'h010203));
		dir_rows.push_back(wr_row(127, 127, 24'hFFFFFF));
		dir_rows.push_back(rd_row(127, 127, 1'b0, 24'hFFFFFF));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// receiver-heavy idling, then sender-heavy, then full rate
			if (ph < 3) begin
				tx_idle_pct = 34;
				rx_idle_pct = 69;
			end else if (ph < 6) begin
				tx_idle_pct = 69;
				rx_idle_pct = 34;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			case (ph)
				0: begin
					foreach (dir_rows[k])
						send_px(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
				end
				// maximum upscale: every in-range read lands on the origin
				1: set_sizes(1, 1, MAX_DST, MAX_DST);
				// zero source sizes act as 1; one zero destination size -> 1x1 output
				2: set_sizes(0, 0, 0, 5);
				// over-range registers clamp to 128x128 source, 1024x1024 output
				3: set_sizes(255, 200, 2047, 1500);
				// maximum downscale to a single pixel
				4: set_sizes(MAX_SW, MAX_SH, 1, 1);
				5: set_sizes(37, 90, 300, 17);
				// small source; writes outside it still land in the store
				6: set_sizes(4, 3, 0, 0);
				7: set_sizes(MAX_SW, MAX_SH, MAX_DST, MAX_DST);
				default: set_sizes($urandom_range(1, MAX_SW), $urandom_range(1, MAX_SH),
						$urandom_range(1, MAX_DST), $urandom_range(1, MAX_DST));
			endcase

			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				// long receiver hold-off while items keep coming: input must stall
				if (i == RAND_PER_PHASE / 3)
					hold_req++;
				// sender pause until the pipeline is empty
				if (i == 2 * RAND_PER_PHASE / 3)
					drain_results();

				q = rand_req();
				eff_sizes(sw, sh, ow, oh);
				sel = $urandom_range(0, 99);
				if (sel < 35) begin
					q.op = OP_WRITE;
					if ($urandom_range(0, 9) < 7) begin
						q.sx = SCRD_W'($urandom_range(0, sw - 1));
						q.sy = SCRD_W'($urandom_range(0, sh - 1));
					end
				end else begin
					q.op = OP_READ;
					// mostly inside the output; the rest anywhere in the 10-bit range
					if (sel < 85) begin
						q.dx = DCRD_W'($urandom_range(0, ow - 1));
						q.dy = DCRD_W'($urandom_range(0, oh - 1));
					end
					// store entries are undefined until written: fill the mapped
					// pixel first when this read would hit a fresh one
					idx = src_index(q.dx, q.dy);
					if (idx >= 0 && !pix_written[idx]) begin
						fill    = rand_req();
						fill.op = OP_WRITE;
						{fill.sy, fill.sx} = idx[2*SCRD_W-1:0];
						send_px(fill, 1'b0, '0);
					end
				end
				send_px(q, 1'b0, '0);
			end

			// sizes change only with the block idle: results out, writes settled
			drain_results();
			repeat (DRAIN_CYCLES) @(posedge clk);
		end

		if (errors == 0)
			$display("tb_nearest_neighbor_image_scaler_unit passed");
		else
			$display("tb_nearest_neighbor_image_scaler_unit failed");
		$finish;
	end

endmodule
